### rtl/life_generation_line_stream_assert.svh
// assertion macros shared by the life line stream rtl
`ifndef LIFE_GENERATION_LINE_STREAM_ASSERT_SVH
`define LIFE_GENERATION_LINE_STREAM_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define LGLS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define LGLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lgls_pkg.sv
// shared types and constants for the life line stream
package lgls_pkg;

   localparam int unsigned FIFO_DEPTH = 2;

   typedef struct packed {
      logic load;
      logic keep;
      logic clear;
   } cell_ctrl_type;

endpackage

### rtl/life_generation_line_stream.sv
// top level: conway life b3/s23 generation over a stream of grid lines
//
//   channel  direction  tdata           tuser       tlast
//   req_     in         line_cells      first_line  last_line
//   rsp_     out        next_cells      -           frame_done
//
// one line per cycle while req_tready is high; a last line is followed by a flush of its own result
// the row of column cells holds the two previous lines and computes the next line combinationally
// results pass through a two-entry queue, so req_tready does not wait on rsp_tready
// reset is synchronous and clears the held lines and the queue
// req_tready drops while the queue is full or a flush is pending
module life_generation_line_stream #(
   parameter int unsigned LINE_CELLS = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((LINE_CELLS + 7) / 8) * 8-1:0] req_tdata,  // line_cells
   input  logic                                req_tuser,  // first_line
   input  logic                                req_tlast,  // last_line
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((LINE_CELLS + 7) / 8) * 8-1:0] rsp_tdata,  // next_cells
   output logic                                rsp_tlast   // frame_done
);

   `include "life_generation_line_stream_assert.svh"

   localparam int unsigned DATA_BITS = ((LINE_CELLS + 7) / 8) * 8;

   logic                    flush_ff;
   logic                    flush_in;
   logic                    mid_valid_ff;
   logic                    mid_valid_in;
   logic                    fifo_full;
   logic                    accept;
   logic                    keep;
   logic                    emit_now;
   logic                    flush_go;
   logic                    push;
   logic [LINE_CELLS-1:0]   line;
   logic [LINE_CELLS-1:0]   below;
   logic [LINE_CELLS+1:0]   below_ext;
   logic [LINE_CELLS+1:0]   up_ext;
   logic [LINE_CELLS+1:0]   mid_ext;
   logic [LINE_CELLS-1:0]   next_row;
   logic [LINE_CELLS:0]     pop_data;
   lgls_pkg::cell_ctrl_type ctrl;

   assign line       = req_tdata[LINE_CELLS-1:0];
   assign req_tready = !flush_ff && !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign keep       = mid_valid_ff && !req_tuser;
   assign emit_now   = accept && keep;
   assign flush_go   = flush_ff && !fifo_full;
   assign push       = emit_now || flush_go;

   assign ctrl.load  = accept;
   assign ctrl.keep  = keep;
   assign ctrl.clear = flush_go;

   // dead line below while flushing the frame's last line
   assign below     = flush_ff ? '0 : line;
   assign below_ext = {1'b0, below, 1'b0};
   assign up_ext[0]             = 1'b0;
   assign up_ext[LINE_CELLS+1]  = 1'b0;
   assign mid_ext[0]            = 1'b0;
   assign mid_ext[LINE_CELLS+1] = 1'b0;

   for (genvar i = 0; i < LINE_CELLS; i++) begin : g_cell
      lgls_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .line_bit    (line[i]),
         .below_left  (below_ext[i]),
         .below_here  (below_ext[i+1]),
         .below_right (below_ext[i+2]),
         .up_left     (up_ext[i]),
         .up_right    (up_ext[i+2]),
         .mid_left    (mid_ext[i]),
         .mid_right   (mid_ext[i+2]),
         .up_bit      (up_ext[i+1]),
         .mid_bit     (mid_ext[i+1]),
         .next_bit    (next_row[i])
      );
   end

   always_comb begin
      flush_in     = flush_ff;
      mid_valid_in = mid_valid_ff;
      if (flush_go) begin
         flush_in     = 1'b0;
         mid_valid_in = 1'b0;
      end else if (accept) begin
         flush_in     = req_tlast;
         mid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff     <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         flush_ff     <= flush_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   lgls_out_fifo #(
      .WIDTH (LINE_CELLS + 1)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({flush_go, next_row}),
      .full      (fifo_full),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .pop_data  (pop_data)
   );

   assign rsp_tdata = DATA_BITS'(pop_data[LINE_CELLS-1:0]);
   assign rsp_tlast = pop_data[LINE_CELLS];

   `LGLS_ASSERT_SAME(a_no_accept_in_flush, clock, reset, flush_ff, !req_tready,
      "line accepted while a flush is pending")
   `LGLS_ASSERT_NEXT(a_last_starts_flush, clock, reset, accept && req_tlast, flush_ff,
      "last line did not start a flush")
   `LGLS_ASSERT_NEXT(a_flush_clears_state, clock, reset, flush_go,
      !mid_valid_ff && !flush_ff, "flush left a pending line")
   `LGLS_ASSERT_SAME(a_single_push, clock, reset, push, !(emit_now && flush_go),
      "two results pushed in one cycle")

endmodule

### rtl/lgls_cell.sv
// one column cell: holds the upper and middle bits and computes the next state
module lgls_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lgls_pkg::cell_ctrl_type ctrl,
   input  logic                  line_bit,
   input  logic                  below_left,
   input  logic                  below_here,
   input  logic                  below_right,
   input  logic                  up_left,
   input  logic                  up_right,
   input  logic                  mid_left,
   input  logic                  mid_right,
   output logic                  up_bit,
   output logic                  mid_bit,
   output logic                  next_bit
);

   logic       upper_ff;
   logic       upper_in;
   logic       middle_ff;
   logic       middle_in;
   logic [3:0] alive_count;

   assign alive_count = 4'(up_left) + 4'(upper_ff) + 4'(up_right)
                      + 4'(mid_left) + 4'(mid_right)
                      + 4'(below_left) + 4'(below_here) + 4'(below_right);

   assign next_bit = (alive_count == 4'd3) || ((alive_count == 4'd2) && middle_ff);

   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      if (ctrl.clear) begin
         upper_in  = 1'b0;
         middle_in = 1'b0;
      end else if (ctrl.load) begin
         upper_in  = ctrl.keep & middle_ff;
         middle_in = line_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

   assign up_bit  = upper_ff;
   assign mid_bit = middle_ff;

endmodule

### rtl/lgls_out_fifo.sv
// two-entry result queue between the cell row and the result channel
module lgls_out_fifo #(
   parameter int unsigned WIDTH = 29
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] data_ff [lgls_pkg::FIFO_DEPTH];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == 2'(lgls_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### tb/life_line_checker.sv
// checker for the life line stream: predicts next-generation lines and compares results
`timescale 1ns / 1ps

module life_line_checker #(
   parameter int unsigned LINE_CELLS = 28,
   parameter int unsigned DATA_W     = ((LINE_CELLS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // line_cells
   input  logic              req_tuser,   // first_line
   input  logic              req_tlast,   // last_line
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,   // next_cells
   input  logic              rsp_tlast,   // frame_done
   output int                outstanding,
   output int                failures,
   output int                results_checked,
   output int                frames_done
);

   typedef logic [LINE_CELLS-1:0] cells_type;

   typedef struct packed {
      cells_type cells;
      logic      done;
   } gen_line_type;

   gen_line_type pending_lines[$];
   cells_type    above_line;
   cells_type    held_line;
   logic         held_valid;
   int           pending_count = 0;
   int           fail_count    = 0;
   int           checked_count = 0;
   int           frame_count   = 0;

   assign outstanding     = pending_count;
   assign failures        = fail_count;
   assign results_checked = checked_count;
   assign frames_done     = frame_count;

   function automatic cells_type life_next_line(cells_type above, cells_type here,
                                                cells_type below);
      cells_type next_line;
      int        n;
      next_line = '0;
      for (int i = 0; i < int'(LINE_CELLS); i++) begin
         n = 0;
         for (int d = -1; d <= 1; d++) begin
            if (i + d >= 0 && i + d < int'(LINE_CELLS)) begin
               n += int'(above[i + d]);
               n += int'(below[i + d]);
               if (d != 0) n += int'(here[i + d]);
            end
         end
         if (n == 3 || (n == 2 && here[i])) next_line[i] = 1'b1;
      end
      return next_line;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      gen_line_type want;
      cells_type    new_line;
      if (reset) begin
         above_line = '0;
         held_line  = '0;
         held_valid = 1'b0;
         pending_lines.delete();
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            new_line = req_tdata[LINE_CELLS-1:0];
            if (req_tuser) begin
               above_line = '0;
               held_line  = '0;
               held_valid = 1'b0;
            end
            if (held_valid)
               pending_lines.push_back(
                  '{life_next_line(above_line, held_line, new_line), 1'b0});
            above_line = held_valid ? held_line : '0;
            held_line  = new_line;
            held_valid = 1'b1;
            if (req_tlast) begin
               pending_lines.push_back('{life_next_line(above_line, held_line, '0), 1'b1});
               above_line = '0;
               held_line  = '0;
               held_valid = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_lines.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_tdata), 64'(0));
            end else begin
               want = pending_lines.pop_front();
               if (rsp_tdata[LINE_CELLS-1:0] !== want.cells)
                  report_mismatch("next_cells", 64'(rsp_tdata[LINE_CELLS-1:0]),
                                  64'(want.cells));
               if (rsp_tlast !== want.done)
                  report_mismatch("frame_done", 64'(rsp_tlast), 64'(want.done));
               checked_count++;
               if (want.done) frame_count++;
            end
         end
         pending_count <= pending_lines.size();
      end
   end

endmodule

### tb/testbench.sv
// testbench top for the life line stream: stimulus, handshake pressure and verdict
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned LINE_CELLS   = 28;
   localparam int unsigned DATA_W       = ((LINE_CELLS + 7) / 8) * 8;
   localparam int unsigned PHASE_ITEMS  = 457;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned TAIL_CYCLES  = 20;

   typedef logic [LINE_CELLS-1:0] cells_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // line_cells
   logic              req_tuser  = 1'b0; // first_line
   logic              req_tlast  = 1'b0; // last_line
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // next_cells
   logic              rsp_tlast;         // frame_done

   int          outstanding;
   int          failures;
   int          results_checked;
   int          frames_done;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int unsigned cycles    = 0;
   int unsigned lines_sent = 0;

   life_generation_line_stream #(
      .LINE_CELLS(LINE_CELLS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   life_line_checker #(
      .LINE_CELLS(LINE_CELLS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .outstanding     (outstanding),
      .failures        (failures),
      .results_checked (results_checked),
      .frames_done     (frames_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic send_line(input cells_type cells, input logic first, input logic last);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(cells);
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lines_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic cells_type random_line();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return cells_type'($urandom & $urandom & $urandom);
         4, 5:    return cells_type'($urandom | $urandom);
         default: return cells_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(input int unsigned length);
      for (int unsigned k = 0; k < length; k++)
         send_line(random_line(), k == 0, k == length - 1);
   endtask

   initial begin : stimulus
      int unsigned phase_sent;
      int unsigned length;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-line frames
      send_line('1, 1'b1, 1'b1);
      send_line('0, 1'b1, 1'b1);
      send_line(cells_type'(28'h0000007), 1'b1, 1'b1);
      // vertical blinker at the low edge
      send_line(cells_type'(28'h0000001), 1'b1, 1'b0);
      send_line(cells_type'(28'h0000001), 1'b0, 1'b0);
      send_line(cells_type'(28'h0000001), 1'b0, 1'b1);
      // full grid
      send_line('1, 1'b1, 1'b0);
      send_line('1, 1'b0, 1'b0);
      send_line('1, 1'b0, 1'b1);
      // gliders against both ends
      send_line(cells_type'(28'h0000002), 1'b1, 1'b0);
      send_line(cells_type'(28'h0000001), 1'b0, 1'b0);
      send_line(cells_type'(28'h0000007), 1'b0, 1'b1);
      send_line(cells_type'(28'h4000000), 1'b1, 1'b0);
      send_line(cells_type'(28'h8000000), 1'b0, 1'b0);
      send_line(cells_type'(28'he000000), 1'b0, 1'b1);
      // new frame mark while a frame is open
      send_line(cells_type'(28'haaaaaaa), 1'b1, 1'b0);
      send_line(cells_type'(28'h5555555), 1'b0, 1'b0);
      send_line(cells_type'(28'h00ff00f), 1'b1, 1'b0);
      send_line(cells_type'(28'hf00ff00), 1'b0, 1'b1);
      // lines without a first mark after a finished frame
      send_line(cells_type'(28'h0000e00), 1'b0, 1'b0);
      send_line(cells_type'(28'h0000e00), 1'b0, 1'b1);
      send_line(cells_type'(28'h8000001), 1'b0, 1'b1);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 71; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         phase_sent = lines_sent;
         while (lines_sent - phase_sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) begin
               length = ($urandom_range(19) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
               send_frame(length);
            end else begin
               send_line(random_line(), $urandom_range(3) == 0, $urandom_range(3) == 0);
            end
         end
         // hold off until the block has handed back everything
         drain_results();
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d grid lines in four pressure phases, incl. split and single-line frames",
               lines_sent);
      $display("checked %0d next-generation lines, %0d of them closing a frame",
               results_checked, frames_done);
      if (failures == 0 && outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/lgls_pkg.sv
rtl/lgls_cell.sv
rtl/lgls_out_fifo.sv
rtl/life_generation_line_stream.sv
tb/life_line_checker.sv
tb/testbench.sv
